### sv/rcmp_pkg.sv
// package for remote_command_motor_pwm: duty struct, decode tables and codes
package rcmp_pkg;

    localparam int DUTY_W  = 7;
    localparam int DIR_W   = 4;
    localparam int CODE_W  = 4;
    localparam int FRAME_W = 8;

    // request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_FRAME = 1'b1;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_STOP      = 4'd0;
    localparam logic [DIR_W-1:0] DIR_FWD       = 4'd1;
    localparam logic [DIR_W-1:0] DIR_SPIN_A    = 4'd2;
    localparam logic [DIR_W-1:0] DIR_SPIN_B    = 4'd3;
    localparam logic [DIR_W-1:0] DIR_BACK      = 4'd4;
    localparam logic [DIR_W-1:0] DIR_VEER_R    = 4'd5;
    localparam logic [DIR_W-1:0] DIR_VEER_L    = 4'd6;
    localparam logic [DIR_W-1:0] DIR_BACK_VR   = 4'd7;
    localparam logic [DIR_W-1:0] DIR_BACK_VL   = 4'd8;

    // high nibble patterns with bit 4 set that change the direction
    localparam logic [3:0] HI_ALL_SET = 4'hF;
    localparam logic [3:0] HI_B4_ONLY = 4'h1;

    // speed code to duty, code*20/3 truncated, one less at multiples of 3
    localparam logic [DUTY_W-1:0] SPEED_TABLE [16] = '{
        7'd0,  7'd6,  7'd13, 7'd19, 7'd26, 7'd33, 7'd39, 7'd46,
        7'd53, 7'd59, 7'd66, 7'd73, 7'd79, 7'd86, 7'd93, 7'd99
    };

    // the same duty divided by three, truncated
    localparam logic [DUTY_W-1:0] THIRD_TABLE [16] = '{
        7'd0,  7'd2,  7'd4,  7'd6,  7'd8,  7'd11, 7'd13, 7'd15,
        7'd17, 7'd19, 7'd22, 7'd24, 7'd26, 7'd28, 7'd31, 7'd33
    };

    typedef struct packed {
        logic [DUTY_W-1:0] right_back;
        logic [DUTY_W-1:0] right_fwd;
        logic [DUTY_W-1:0] left_back;
        logic [DUTY_W-1:0] left_fwd;
    } t_duties;

endpackage

### sv/rcmp_if.sv
// stream interfaces for command input and motor result output
interface rcmp_cmd_if;
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic [rcmp_pkg::FRAME_W-1:0]    frame_bits;

    modport source (output valid, output req_type, output frame_bits, input ready);
    modport sink   (input valid, input req_type, input frame_bits, output ready);
endinterface

interface rcmp_res_if;
    logic                            valid;
    logic                            ready;
    logic                            right_back_pin;
    logic                            right_fwd_pin;
    logic                            left_back_pin;
    logic                            left_fwd_pin;
    logic [rcmp_pkg::DIR_W-1:0]      direction_code;
    logic [rcmp_pkg::DUTY_W-1:0]     speed_duty;

    modport source (output valid, output right_back_pin, output right_fwd_pin,
                    output left_back_pin, output left_fwd_pin,
                    output direction_code, output speed_duty, input ready);
    modport sink   (input valid, input right_back_pin, input right_fwd_pin,
                    input left_back_pin, input left_fwd_pin,
                    input direction_code, input speed_duty, output ready);
endinterface

### sv/rcmp_duty_mix.sv
// maps direction and speed code to the four motor duties
module rcmp_duty_mix (
    input  logic [rcmp_pkg::DIR_W-1:0]  i_dir,
    input  logic [rcmp_pkg::CODE_W-1:0] i_code,
    output rcmp_pkg::t_duties           o_duties
);

    logic [rcmp_pkg::DUTY_W-1:0] w_full;
    logic [rcmp_pkg::DUTY_W-1:0] w_third;

    assign w_full  = rcmp_pkg::SPEED_TABLE[i_code];
    assign w_third = rcmp_pkg::THIRD_TABLE[i_code];

    always_comb begin
        o_duties = '0;
        case (i_dir)
            rcmp_pkg::DIR_FWD: begin
                o_duties.right_fwd = w_full;
                o_duties.left_fwd  = w_full;
            end
            rcmp_pkg::DIR_SPIN_A: begin
                o_duties.right_fwd = w_full;
                o_duties.left_back = w_full;
            end
            rcmp_pkg::DIR_SPIN_B: begin
                o_duties.right_back = w_full;
                o_duties.left_fwd   = w_full;
            end
            rcmp_pkg::DIR_BACK: begin
                o_duties.right_back = w_full;
                o_duties.left_back  = w_full;
            end
            rcmp_pkg::DIR_VEER_R: begin
                o_duties.right_fwd = w_full;
                o_duties.left_fwd  = w_third;
            end
            rcmp_pkg::DIR_VEER_L: begin
                o_duties.right_fwd = w_third;
                o_duties.left_fwd  = w_full;
            end
            rcmp_pkg::DIR_BACK_VR: begin
                o_duties.right_back = w_third;
                o_duties.left_back  = w_full;
            end
            rcmp_pkg::DIR_BACK_VL: begin
                o_duties.right_back = w_full;
                o_duties.left_back  = w_third;
            end
            default: begin
                o_duties = '0;
            end
        endcase
    end

endmodule

### sv/remote_command_motor_pwm.sv
// top level: remote command decode and four-pin motor pwm
//
//  channel  | dir | payload
//  i_cmd    | in  | req_type, frame_bits
//  o_res    | out | four pin levels, direction_code, speed_duty
//
// one transfer in per cycle while i_cmd.ready is high, result in the output register in the next cycle
// the output register decouples the sides: a new transfer is taken while the
// result leaves, and only a held result with o_res.ready low stalls i_cmd
// reset clears counter, direction, speed, duties, pins and output valid
// a frame changes duties from the next tick on; its result shows the old pins
module remote_command_motor_pwm #(
    parameter int PWM_TOP = 100
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rcmp_cmd_if.sink     i_cmd,
    rcmp_res_if.source   o_res
);

    localparam int CW   = $clog2(PWM_TOP + 1);
    localparam int CMPW = (CW > rcmp_pkg::DUTY_W) ? CW : rcmp_pkg::DUTY_W;

    logic [CW-1:0]                 r_count, n_count;
    logic [CW:0]                   w_inc;
    logic [rcmp_pkg::DIR_W-1:0]    r_dir, n_dir;
    logic [rcmp_pkg::DUTY_W-1:0]   r_speed, n_speed;
    rcmp_pkg::t_duties             r_duty, n_duty, w_mix;
    logic [3:0]                    r_pins, n_pins;
    logic                          r_out_valid;
    logic                          w_accept;
    logic [3:0]                    w_hi;

    assign i_cmd.ready = i_rst_n && (!r_out_valid || o_res.ready);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_hi        = i_cmd.frame_bits[7:4];

    rcmp_duty_mix u_mix (
        .i_dir    (n_dir),
        .i_code   (i_cmd.frame_bits[3:0]),
        .o_duties (w_mix)
    );

    assign w_inc = {1'b0, r_count} + (CW+1)'(1);

    always_comb begin
        n_count = r_count;
        n_dir   = r_dir;
        n_speed = r_speed;
        n_duty  = r_duty;
        n_pins  = r_pins;
        if (i_cmd.req_type == rcmp_pkg::REQ_TICK) begin
            n_count = (w_inc > (CW+1)'(PWM_TOP)) ? '0 : w_inc[CW-1:0];
            n_pins[3] = CMPW'(n_count) <= CMPW'(r_duty.right_back);
            n_pins[2] = CMPW'(n_count) <= CMPW'(r_duty.right_fwd);
            n_pins[1] = CMPW'(n_count) <= CMPW'(r_duty.left_back);
            n_pins[0] = CMPW'(n_count) <= CMPW'(r_duty.left_fwd);
        end else begin
            n_speed = rcmp_pkg::SPEED_TABLE[i_cmd.frame_bits[3:0]];
            // weights: bit5 -> 4, bit6 -> 2, bit7 -> 1
            if (!w_hi[0]) begin
                n_dir = {1'b0, w_hi[1], w_hi[2], w_hi[3]};
            end else if (w_hi == rcmp_pkg::HI_ALL_SET) begin
                n_dir = rcmp_pkg::DIR_FWD;
            end else if (w_hi == rcmp_pkg::HI_B4_ONLY) begin
                n_dir = rcmp_pkg::DIR_BACK_VL;
            end
            n_duty = w_mix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dir       <= rcmp_pkg::DIR_STOP;
            r_speed     <= '0;
            r_duty      <= '0;
            r_pins      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_dir       <= n_dir;
                r_speed     <= n_speed;
                r_duty      <= n_duty;
                r_pins      <= n_pins;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.right_back_pin = r_pins[3];
    assign o_res.right_fwd_pin  = r_pins[2];
    assign o_res.left_back_pin  = r_pins[1];
    assign o_res.left_fwd_pin   = r_pins[0];
    assign o_res.direction_code = r_dir;
    assign o_res.speed_duty     = r_speed;

endmodule

### sv/rcmp_checker.sv
// port-level checker for remote_command_motor_pwm and its bind
module rcmp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic                          i_req_type,
    input logic [rcmp_pkg::FRAME_W-1:0]  i_frame_bits,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [3:0]                    i_pins,
    input logic [rcmp_pkg::DIR_W-1:0]    i_dir,
    input logic [rcmp_pkg::DUTY_W-1:0]   i_speed
);

    // held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_pins) && $stable(i_dir)
            && $stable(i_speed))
        else $error("result changed while stalled");

    // decoded fields stay in their ranges
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_dir <= rcmp_pkg::DIR_BACK_VL) && (i_speed <= 7'd99))
        else $error("direction or speed out of range");

    // speed code zero gives zero duty on the next result
    a_speed0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && i_req_type == rcmp_pkg::REQ_FRAME
            && i_frame_bits[3:0] == 4'd0 |=> i_res_valid && i_speed == 7'd0)
        else $error("speed code zero not decoded");

    // all high bits set selects forward
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && i_req_type == rcmp_pkg::REQ_FRAME
            && i_frame_bits[7:4] == rcmp_pkg::HI_ALL_SET
            |=> i_res_valid && i_dir == rcmp_pkg::DIR_FWD)
        else $error("forward pattern not decoded");

endmodule

bind remote_command_motor_pwm rcmp_checker u_rcmp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_cmd.valid),
    .i_ready      (i_cmd.ready),
    .i_req_type   (i_cmd.req_type),
    .i_frame_bits (i_cmd.frame_bits),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_pins       ({o_res.right_back_pin, o_res.right_fwd_pin,
                    o_res.left_back_pin, o_res.left_fwd_pin}),
    .i_dir        (o_res.direction_code),
    .i_speed      (o_res.speed_duty)
);

### tb/sv/rcmp_checker.sv
`timescale 1ns / 1ps
// checker for remote_command_motor_pwm: predicts pins, direction and speed and compares them
module rcmp_scoreboard #(
    parameter int PWM_TOP = 100
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rcmp_cmd_if   i_cmd,
    rcmp_res_if   i_res,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        logic                        right_back;
        logic                        right_fwd;
        logic                        left_back;
        logic                        left_fwd;
        logic [rcmp_pkg::DIR_W-1:0]  direction;
        logic [rcmp_pkg::DUTY_W-1:0] speed;
    } t_drive;

    logic [7:0]                  tick_cnt;
    logic [rcmp_pkg::DIR_W-1:0]  direction;
    logic [rcmp_pkg::DUTY_W-1:0] speed;
    rcmp_pkg::t_duties           duty;
    logic [3:0]                  pin_level;   // right_back, right_fwd, left_back, left_fwd
    t_drive                      drive_q[$];
    int                          fail_total = 0;

    // code * 20/3 truncated, one step under at exact multiples of three
    function automatic logic [rcmp_pkg::DUTY_W-1:0] speed_of_code(input logic [3:0] code);
        if (code == 4'd0) begin
            return '0;
        end
        return rcmp_pkg::DUTY_W'((int'(code) * 20 - 1) / 3);
    endfunction

    function automatic rcmp_pkg::t_duties duties_for(
            input logic [rcmp_pkg::DIR_W-1:0] dir,
            input logic [rcmp_pkg::DUTY_W-1:0] s);
        logic [rcmp_pkg::DUTY_W-1:0] t;
        t = s / 3;
        case (dir)
            rcmp_pkg::DIR_FWD:     return '{'0, s,  '0, s};
            rcmp_pkg::DIR_SPIN_A:  return '{'0, s,  s,  '0};
            rcmp_pkg::DIR_SPIN_B:  return '{s,  '0, '0, s};
            rcmp_pkg::DIR_BACK:    return '{s,  '0, s,  '0};
            rcmp_pkg::DIR_VEER_R:  return '{'0, s,  '0, t};
            rcmp_pkg::DIR_VEER_L:  return '{'0, t,  '0, s};
            rcmp_pkg::DIR_BACK_VR: return '{t,  '0, s,  '0};
            rcmp_pkg::DIR_BACK_VL: return '{s,  '0, t,  '0};
            default:               return '0;
        endcase
    endfunction

    function automatic void advance_pwm();
        logic [7:0] next;
        next = tick_cnt + 8'd1;
        if (next > PWM_TOP) begin
            next = '0;
        end
        tick_cnt = next;
        pin_level = {next <= duty.right_back, next <= duty.right_fwd,
                     next <= duty.left_back,  next <= duty.left_fwd};
    endfunction

    function automatic void decode_frame(input logic [rcmp_pkg::FRAME_W-1:0] fb);
        logic [3:0] hi;
        hi = fb[7:4];
        speed = speed_of_code(fb[3:0]);
        if (!hi[0]) begin
            // weights: bit 5 four, bit 6 two, bit 7 one
            direction = rcmp_pkg::DIR_W'({hi[1], hi[2], hi[3]});
        end else if (hi == rcmp_pkg::HI_ALL_SET) begin
            direction = rcmp_pkg::DIR_FWD;
        end else if (hi == rcmp_pkg::HI_B4_ONLY) begin
            direction = rcmp_pkg::DIR_BACK_VL;
        end
        duty = duties_for(direction, speed);
    endfunction

    function automatic void check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s expected %0d actual %0d", name, exp_val, act_val);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_drive want;
        if (!i_rst_n) begin
            tick_cnt  = '0;
            direction = rcmp_pkg::DIR_STOP;
            speed     = '0;
            duty      = '0;
            pin_level = '0;
            drive_q.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                if (i_cmd.req_type == rcmp_pkg::REQ_TICK) begin
                    advance_pwm();
                end else begin
                    decode_frame(i_cmd.frame_bits);
                end
                drive_q.push_back({pin_level, direction, speed});
            end
            if (i_res.valid && i_res.ready) begin
                if (drive_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fail_total++;
                end else begin
                    want = drive_q.pop_front();
                    check_field("right_back_pin", want.right_back, i_res.right_back_pin);
                    check_field("right_fwd_pin", want.right_fwd, i_res.right_fwd_pin);
                    check_field("left_back_pin", want.left_back, i_res.left_back_pin);
                    check_field("left_fwd_pin", want.left_fwd, i_res.left_fwd_pin);
                    check_field("direction_code", want.direction, i_res.direction_code);
                    check_field("speed_duty", want.speed, i_res.speed_duty);
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= drive_q.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench top for remote_command_motor_pwm: clock, reset, stimulus and verdict
module testbench;

    localparam int RANDOM_ITEMS = 1825;
    localparam int CYCLE_LIMIT  = 200000;

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;

    rcmp_cmd_if cmd_bus ();
    rcmp_res_if res_bus ();

    remote_command_motor_pwm dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    rcmp_scoreboard drive_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_bus),
        .i_res        (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        res_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // holds the transfer until the block takes it
    task automatic send_cmd(input logic req, input logic [rcmp_pkg::FRAME_W-1:0] fb);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.req_type   <= req;
        cmd_bus.frame_bits <= fb;
        do @(posedge i_clk); while (!cmd_bus.ready);
    endtask

    task automatic send_random();
        if ($urandom_range(99) < 12) begin
            send_cmd(rcmp_pkg::REQ_FRAME, rcmp_pkg::FRAME_W'($urandom_range(255)));
        end else begin
            send_cmd(rcmp_pkg::REQ_TICK, rcmp_pkg::FRAME_W'($urandom_range(255)));
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.req_type   = rcmp_pkg::REQ_TICK;
        cmd_bus.frame_bits = '0;
        src_idle_pct       = 0;
        snk_idle_pct       = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every high nibble pattern, every speed code, then the extremes
        send_cmd(rcmp_pkg::REQ_TICK, '0);
        for (int k = 0; k < 16; k++) begin
            send_cmd(rcmp_pkg::REQ_FRAME, {4'(k), 4'(15 - k)});
        end
        send_cmd(rcmp_pkg::REQ_FRAME, 8'h00);
        send_cmd(rcmp_pkg::REQ_FRAME, 8'hFF);
        repeat (6) send_cmd(rcmp_pkg::REQ_TICK, 8'hA5);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 47 : 0;
            snk_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 30 : 0;
            repeat (RANDOM_ITEMS / 3) send_random();
        end
        cmd_bus.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
